### sv/insertion_sort_engine_assert.svh
// assertion macros for the insertion sort engine checker
// depends on a clk and rst in the scope of use
`ifndef INSERTION_SORT_ENGINE_ASSERT_SVH
`define INSERTION_SORT_ENGINE_ASSERT_SVH

// same-cycle implication
`define ISE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("insertion sort engine check failed");

// next-cycle implication
`define ISE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("insertion sort engine check failed");

`endif

### sv/ise_pkg.sv
// shared constants and types for the insertion sort engine
// no dependencies
package ise_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int KEY_W     = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic insert;
    logic drain;
    logic descending;
  } cell_ctl_t;

endpackage

### sv/ise_cell.sv
// one compare-and-shift cell of the sorted chain
// depends on ise_pkg
module ise_cell import ise_pkg::*; (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [KEY_W-1:0] new_key,
  input  logic                    occupied,
  input  logic                    is_slot,
  input  logic signed [KEY_W-1:0] prev_key,
  input  logic                    prev_moves,
  input  logic signed [KEY_W-1:0] next_key,
  output logic signed [KEY_W-1:0] key,
  output logic                    moves
);

  logic goes_after;
  logic take;

  // held key must sit behind the new one
  assign goes_after = ctl.descending ? (key < new_key) : (key > new_key);
  assign moves      = occupied && goes_after;
  assign take       = ctl.insert && (occupied ? goes_after : is_slot);

  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      key <= next_key;
    end else if (take) begin
      key <= prev_moves ? prev_key : new_key;
    end
  end

endmodule

### sv/insertion_sort_engine.sv
// Insertion sort engine: a row of MAX_ITEMS compare-and-shift cells holds the batch in sorted
// order. Every key is inserted in the cycle it is accepted (start high, busy low), so keys may
// arrive back to back at one per cycle. After the key marked batch_end, busy stays high while
// the n held keys leave one word per cycle on res_valid, shifted down the row from cell 0; the
// receiver cannot stall and must take each word in its cycle. A new batch may start in the cycle
// after the word marked final_res. Keys beyond capacity are dropped and overflowed is raised on
// every word of that batch. The user writes descending only between batches (not enforced).
// depends on ise_pkg and ise_cell
module insertion_sort_engine import ise_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [KEY_W-1:0] key,
  input  logic                    batch_end,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  output logic                    res_valid,
  output logic signed [KEY_W-1:0] sorted_key,
  output logic                    final_res,
  output logic                    overflowed
);

  state_t state, state_next;
  logic [CNT_W-1:0] held_count;
  logic dropped;
  logic descending;
  logic accept;
  logic full;
  logic last_word;
  cell_ctl_t ctl;

  logic signed [KEY_W-1:0] cell_key [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_moves;
  logic [MAX_ITEMS-1:0] occ;
  logic [MAX_ITEMS-1:0] slot;

  assign accept    = start && !busy;
  assign full      = (held_count == CNT_W'(MAX_ITEMS));
  assign last_word = (held_count == CNT_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && batch_end) state_next = ST_DRAIN;
      ST_DRAIN: if (last_word) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      ST_IDLE:  busy = 1'b0;
      ST_DRAIN: begin
        busy      = 1'b1;
        res_valid = 1'b1;
      end
      default:  busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
      dropped    <= 1'b0;
      descending <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        descending <= cfg_wdata;
      end
      if (accept) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          held_count <= held_count + CNT_W'(1);
        end
      end else if (res_valid) begin
        held_count <= held_count - CNT_W'(1);
        if (last_word) begin
          dropped <= 1'b0;
        end
      end
    end
  end

  assign ctl.insert     = accept && !full;
  assign ctl.drain      = res_valid;
  assign ctl.descending = descending;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      logic signed [KEY_W-1:0] prev_k;
      logic signed [KEY_W-1:0] next_k;
      logic                    prev_m;

      assign occ[gi]  = (held_count > CNT_W'(gi));
      assign slot[gi] = (held_count == CNT_W'(gi));

      if (gi == 0) begin : g_first
        assign prev_k = '0;
        assign prev_m = 1'b0;
      end else begin : g_mid
        assign prev_k = cell_key[gi-1];
        assign prev_m = cell_moves[gi-1];
      end

      if (gi == MAX_ITEMS - 1) begin : g_last
        assign next_k = '0;
      end else begin : g_up
        assign next_k = cell_key[gi+1];
      end

      ise_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_key    (key),
        .occupied   (occ[gi]),
        .is_slot    (slot[gi]),
        .prev_key   (prev_k),
        .prev_moves (prev_m),
        .next_key   (next_k),
        .key        (cell_key[gi]),
        .moves      (cell_moves[gi])
      );
    end
  endgenerate

  assign sorted_key = cell_key[0];
  assign final_res  = res_valid && last_word;
  assign overflowed = dropped;

endmodule

### sv/ise_checker.sv
// port-level checks on the insertion sort engine, bound to the top level
// depends on insertion_sort_engine_assert.svh
`include "insertion_sort_engine_assert.svh"

module ise_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic batch_end,
  input logic res_valid,
  input logic final_res,
  input logic overflowed
);

  `ISE_ASSERT_NEXT(a_end_starts_drain, start && !busy && batch_end, busy && res_valid)
  `ISE_ASSERT_NEXT(a_final_frees, res_valid && final_res, !busy && !res_valid)
  `ISE_ASSERT_NEXT(a_drain_continues, res_valid && !final_res, res_valid)
  `ISE_ASSERT_NEXT(a_flag_steady, res_valid && !final_res, $stable(overflowed))
  `ISE_ASSERT_NOW(a_word_while_busy, !busy, !res_valid && !final_res)

endmodule

bind insertion_sort_engine ise_checker u_ise_checker (.*);

### test/tb.sv
// self-checking testbench for insertion_sort_engine: streams key batches and checks every sorted word
// an in-bench sorter predicts each batch; depends on ise_pkg and the engine rtl
`timescale 1ns / 1ps

module tb import ise_pkg::*; ();

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_KEYS = 152;

  typedef struct {
    logic signed [KEY_W-1:0] sorted_key;
    logic                    last_word;
    logic                    overflowed;
  } sorted_word_t;

  class sorted_batch_board;
    logic signed [KEY_W-1:0] held_keys [MAX_ITEMS];
    int held;
    bit dropped;
    bit descending;
    int errors;
    sorted_word_t due_words[$];

    function new();
      held = 0;
      dropped = 1'b0;
      descending = 1'b1;
      errors = 0;
    endfunction

    function void take_key(logic signed [KEY_W-1:0] k, logic last);
      int pos;
      sorted_word_t w;
      if (held == MAX_ITEMS) begin
        dropped = 1'b1;
      end else begin
        pos = held;
        while (pos > 0 && (descending ? (held_keys[pos-1] < k) : (held_keys[pos-1] > k))) begin
          held_keys[pos] = held_keys[pos-1];
          pos--;
        end
        held_keys[pos] = k;
        held++;
      end
      if (last) begin
        for (int i = 0; i < held; i++) begin
          w.sorted_key = held_keys[i];
          w.last_word = (i == held - 1);
          w.overflowed = dropped;
          due_words = {due_words, w};
        end
        held = 0;
        dropped = 1'b0;
      end
    endfunction

    function void check_word(logic signed [KEY_W-1:0] k, logic last, logic ovf);
      sorted_word_t w;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual key %0d", $time, k);
        errors++;
      end else begin
        w = due_words.pop_front();
        if (k !== w.sorted_key) begin
          $display("%0t: sorted_key expected %0d actual %0d", $time, w.sorted_key, k);
          errors++;
        end
        if (last !== w.last_word) begin
          $display("%0t: final_res expected %0b actual %0b", $time, w.last_word, last);
          errors++;
        end
        if (ovf !== w.overflowed) begin
          $display("%0t: overflowed expected %0b actual %0b", $time, w.overflowed, ovf);
          errors++;
        end
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic signed [KEY_W-1:0] key;
  logic                    batch_end;
  logic                    cfg_we;
  logic                    cfg_wdata;
  logic                    res_valid;
  logic signed [KEY_W-1:0] sorted_key;
  logic                    final_res;
  logic                    overflowed;

  sorted_batch_board board = new();
  bit gaps_on;
  int idle_cycles = 0;
  int random_sent;

  insertion_sort_engine uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .key(key),
    .batch_end(batch_end),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .res_valid(res_valid),
    .sorted_key(sorted_key),
    .final_res(final_res),
    .overflowed(overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst && res_valid) begin
      board.check_word(sorted_key, final_res, overflowed);
    end
    if (!rst && start && !busy) begin
      board.take_key(key, batch_end);
    end
    if (!rst && (res_valid || (start && !busy))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [KEY_W-1:0] random_key();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_key(input logic signed [KEY_W-1:0] k, input logic last);
    while (gaps_on && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      key <= $urandom;
      batch_end <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    start <= 1'b1;
    key <= k;
    batch_end <= last;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_order(input bit desc);
    start <= 1'b0;
    @(posedge clk);
    while (board.due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.descending = desc;
  endtask

  task automatic send_batch(input int n);
    for (int i = 0; i < n; i++) begin
      send_key(random_key(), i == n - 1);
      random_sent++;
    end
  endtask

  initial begin
    int batch_no;
    rst <= 1'b1;
    start <= 1'b0;
    key <= '0;
    batch_end <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    gaps_on = 1'b0;
    random_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset order is descending
    send_key(0, 1'b0);
    send_key(32'sh7fffffff, 1'b0);
    send_key(32'sh80000000, 1'b0);
    send_key(-1, 1'b0);
    send_key(1, 1'b0);
    send_key(5, 1'b0);
    send_key(5, 1'b1);

    write_order(1'b0);
    send_key(32'sh7fffffff, 1'b0);
    send_key(3, 1'b0);
    send_key(32'sh80000000, 1'b0);
    send_key(3, 1'b0);
    send_key(-7, 1'b0);
    send_key(0, 1'b0);
    send_key(3, 1'b1);
    // single word batch
    send_key(32'sh80000000, 1'b1);

    write_order(1'b1);
    send_key(42, 1'b0);
    send_key(42, 1'b0);
    send_key(-42, 1'b1);

    // full store back to back, then an overflowing batch with gaps
    send_batch(MAX_ITEMS);
    gaps_on = 1'b1;
    write_order(1'b0);
    send_batch(MAX_ITEMS + 1 + $urandom_range(0, 4));

    batch_no = 0;
    while (random_sent < RANDOM_KEYS) begin
      if ($urandom_range(0, 2) == 0) begin
        write_order(1'($urandom_range(0, 1)));
      end
      gaps_on = (batch_no % 6 != 5);
      send_batch($urandom_range(1, 10));
      batch_no++;
    end
    gaps_on = 1'b1;

    start <= 1'b0;
    @(posedge clk);
    while (board.due_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/ise_pkg.sv
sv/ise_cell.sv
sv/insertion_sort_engine.sv
sv/ise_checker.sv
test/tb.sv
